### rtl/isc_pkg.sv
// Package with the shared types and constants of the integer field scanner.
`default_nettype none

package isc_pkg;

	localparam int COUNT_BITS = 16;
	localparam int WIDTH_BITS = 8;
	localparam int VALUE_BITS = 64;
	localparam int CFG_INDEX_BITS = 2;
	localparam int CFG_DATA_BITS = 8;

	localparam logic [CFG_INDEX_BITS-1:0] CFG_CONV_KIND = 2'd0;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_LENGTH_MODE = 2'd1;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_FIELD_WIDTH = 2'd2;

	localparam logic [1:0] KIND_SIGNED = 2'd0;
	localparam logic [1:0] KIND_OCTAL = 2'd1;
	localparam logic [1:0] KIND_UNSIGNED = 2'd2;
	localparam logic [1:0] KIND_HEX = 2'd3;

	localparam logic [1:0] LEN_SHORT = 2'd0;
	localparam logic [1:0] LEN_INT = 2'd1;
	localparam logic [1:0] LEN_LONG = 2'd2;

	localparam logic [VALUE_BITS-1:0] SIGNED_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [VALUE_BITS-1:0] UNSIGNED_MAX = 64'hFFFF_FFFF_FFFF_FFFF;

	typedef struct packed {
		logic [7:0] ch;
		logic       field_start;
	} scan_item_t;

	typedef struct packed {
		logic [VALUE_BITS-1:0] value;
		logic                  matched;
		logic [COUNT_BITS-1:0] consumed_count;
		logic                  last_char_taken;
	} scan_result_t;

endpackage

`default_nettype wire

### rtl/integer_field_scanner_unit.sv
// Top level of the integer field scanner: one text character per beat in, one field result out.
//
// The block scans one integer field from text that arrives one character per
// input beat, skipping leading blanks and taking an optional sign or 0x prefix
// as the configured conversion allows. When the field ends, one result beat
// carries the value cut to the selected length, a match flag, the count of
// characters consumed and whether the ending character belonged to the field.
// Characters after the end of a field are dropped until a beat with field_start.
// The configuration registers are written through cfg_write, cfg_index and
// cfg_data; the user must write them only while no character is in flight, as the block does not enforce this.
// An accepted beat lands in the input register and is scanned from there; the
// result of the character that ends the field is then registered in the result register.
// One character is accepted every cycle while no result is stalled; the scan state update is
// combinational from the input register, so the multiply-add and saturation compare set the clock.
// While the receiver stalls a valid result, the result register holds and, if the input register
// is empty, one more character is taken into it before item_stall rises.
// Reset clears the scan state to blank skipping with a field already open and
// loads the registers with signed decimal, int length and unlimited width.

`default_nettype none

module integer_field_scanner_unit (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               item_valid,
	output logic                              item_stall,
	input  wire  isc_pkg::scan_item_t         item,
	output logic                              result_valid,
	input  wire                               result_stall,
	output isc_pkg::scan_result_t             result,
	input  wire                               cfg_write,
	input  wire  [isc_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  wire  [isc_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
	import isc_pkg::*;

	localparam logic [2:0] PH_BLANK = 3'd0;
	localparam logic [2:0] PH_SIGNED = 3'd1;
	localparam logic [2:0] PH_ZERO = 3'd2;
	localparam logic [2:0] PH_PREFIX = 3'd3;
	localparam logic [2:0] PH_DIGITS = 3'd4;
	localparam logic [2:0] PH_DONE = 3'd5;

	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB = 8'h09;
	localparam logic [7:0] CH_NEWLINE = 8'h0A;
	localparam logic [7:0] CH_PLUS = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_NINE = 8'h39;
	localparam logic [7:0] CH_LOW_A = 8'h61;
	localparam logic [7:0] CH_LOW_F = 8'h66;
	localparam logic [7:0] CH_UP_A = 8'h41;
	localparam logic [7:0] CH_UP_F = 8'h46;
	localparam logic [7:0] CH_LOW_X = 8'h78;

	// Returns the hex digit value, with the top bit set for a non-digit.
	function automatic logic [4:0] digit_code(input logic [7:0] c);
		logic [7:0] d;
		d = 8'd0;
		if (c >= CH_ZERO && c <= CH_NINE) begin
			d = c - CH_ZERO;
			return {1'b0, d[3:0]};
		end
		if (c >= CH_LOW_A && c <= CH_LOW_F) begin
			d = c - CH_LOW_A + 8'd10;
			return {1'b0, d[3:0]};
		end
		if (c >= CH_UP_A && c <= CH_UP_F) begin
			d = c - CH_UP_A + 8'd10;
			return {1'b0, d[3:0]};
		end
		return 5'h10;
	endfunction

	logic [1:0]            kind_q;
	logic [1:0]            len_q;
	logic [WIDTH_BITS-1:0] width_q;

	scan_item_t item_s1;
	logic       valid_s1;

	logic [2:0]            phase_q;
	logic [VALUE_BITS-1:0] acc_q;
	logic                  neg_q;
	logic                  sat_q;
	logic                  hex_q;
	logic [WIDTH_BITS-1:0] left_q;
	logic                  seen_q;
	logic [COUNT_BITS-1:0] count_q;

	scan_result_t result_q;
	logic         result_valid_q;

	logic advance;
	logic load_s1;

	logic [2:0]            n_phase;
	logic [VALUE_BITS-1:0] n_acc;
	logic                  n_neg;
	logic                  n_sat;
	logic                  n_hex;
	logic [WIDTH_BITS-1:0] n_left;
	logic                  n_seen;
	logic [COUNT_BITS-1:0] n_count;

	logic                  emit;
	logic                  taken;
	logic                  do_digit;
	logic [7:0]            c;
	logic                  blank;
	logic [4:0]            code;
	logic                  digit_ok;
	logic                  base8;
	logic                  base16;
	logic [67:0]           prod;
	logic [68:0]           sum;
	logic [VALUE_BITS-1:0] limit;
	logic                  over;
	logic [VALUE_BITS-1:0] signed_val;
	logic [VALUE_BITS-1:0] cut_val;
	scan_result_t          fin;

	assign advance = !(result_valid_q && result_stall);
	assign load_s1 = !valid_s1 || advance;
	assign item_stall = !load_s1;
	assign result_valid = result_valid_q;
	assign result = result_q;

	always_comb begin
		c = item_s1.ch;
		blank = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_NEWLINE);
		if (item_s1.field_start) begin
			n_phase = PH_BLANK;
			n_acc = '0;
			n_neg = 1'b0;
			n_sat = 1'b0;
			n_hex = 1'b0;
			n_left = '0;
			n_seen = 1'b0;
			n_count = '0;
		end else begin
			n_phase = phase_q;
			n_acc = acc_q;
			n_neg = neg_q;
			n_sat = sat_q;
			n_hex = hex_q;
			n_left = left_q;
			n_seen = seen_q;
			n_count = count_q;
		end
		emit = 1'b0;
		taken = 1'b0;
		do_digit = 1'b0;

		unique case (n_phase)
			PH_BLANK: begin
				if (blank) begin
					if (n_count != '1) n_count = n_count + 1'b1;
				end else begin
					n_left = width_q;
					if (kind_q == KIND_SIGNED && (c == CH_PLUS || c == CH_MINUS)) begin
						n_neg = (c == CH_MINUS);
						if (n_count != '1) n_count = n_count + 1'b1;
						n_phase = PH_SIGNED;
					end else if ((kind_q == KIND_SIGNED || kind_q == KIND_HEX)
							&& c == CH_ZERO) begin
						if (n_count != '1) n_count = n_count + 1'b1;
						n_phase = PH_ZERO;
					end else begin
						do_digit = 1'b1;
					end
				end
			end
			PH_ZERO: begin
				if (c == CH_LOW_X) begin
					if (n_count != '1) n_count = n_count + 1'b1;
					n_hex = 1'b1;
					n_phase = PH_PREFIX;
				end else begin
					n_seen = 1'b1;
					n_phase = PH_DIGITS;
					if (n_left == WIDTH_BITS'(1)) begin
						emit = 1'b1;
					end else begin
						if (n_left > WIDTH_BITS'(1)) n_left = n_left - 1'b1;
						do_digit = 1'b1;
					end
				end
			end
			PH_SIGNED, PH_PREFIX, PH_DIGITS: begin
				do_digit = 1'b1;
			end
			default: begin
			end
		endcase

		base8 = (kind_q == KIND_OCTAL);
		base16 = (kind_q == KIND_HEX) || (kind_q == KIND_SIGNED && n_hex);
		code = digit_code(c);
		if (base8) digit_ok = (code < 5'd8);
		else if (base16) digit_ok = !code[4];
		else digit_ok = (code < 5'd10);

		if (base8) prod = {1'b0, n_acc, 3'b000};
		else if (base16) prod = {n_acc, 4'b0000};
		else prod = {1'b0, n_acc, 3'b000} + {3'b000, n_acc, 1'b0};
		sum = {1'b0, prod} + {65'd0, code[3:0]};
		limit = (kind_q == KIND_SIGNED && !n_hex) ? SIGNED_MAX : UNSIGNED_MAX;
		over = (sum > {5'd0, limit});

		if (do_digit) begin
			if (!digit_ok) begin
				emit = 1'b1;
			end else begin
				if (n_count != '1) n_count = n_count + 1'b1;
				if (!n_sat) begin
					n_acc = over ? limit : sum[VALUE_BITS-1:0];
					n_sat = over;
				end
				n_seen = 1'b1;
				n_phase = PH_DIGITS;
				if (n_left == WIDTH_BITS'(1)) begin
					emit = 1'b1;
					taken = 1'b1;
				end else if (n_left > WIDTH_BITS'(1)) begin
					n_left = n_left - 1'b1;
				end
			end
		end
		if (emit) n_phase = PH_DONE;

		signed_val = n_neg ? (VALUE_BITS'(0) - n_acc) : n_acc;
		unique case (len_q)
			LEN_SHORT: cut_val = {48'd0, signed_val[15:0]};
			LEN_INT: cut_val = {32'd0, signed_val[31:0]};
			default: cut_val = signed_val;
		endcase
		fin.value = n_seen ? cut_val : '0;
		fin.matched = n_seen;
		fin.consumed_count = n_count;
		fin.last_char_taken = taken;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q <= KIND_SIGNED;
			len_q <= LEN_INT;
			width_q <= '0;
		end else if (cfg_write) begin
			unique case (cfg_index)
				CFG_CONV_KIND: kind_q <= cfg_data[1:0];
				CFG_LENGTH_MODE: len_q <= cfg_data[1:0];
				CFG_FIELD_WIDTH: width_q <= cfg_data[WIDTH_BITS-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load_s1) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1 && item_valid) begin
			item_s1 <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_BLANK;
			acc_q <= '0;
			neg_q <= 1'b0;
			sat_q <= 1'b0;
			hex_q <= 1'b0;
			left_q <= '0;
			seen_q <= 1'b0;
			count_q <= '0;
		end else if (valid_s1 && advance) begin
			phase_q <= n_phase;
			acc_q <= n_acc;
			neg_q <= n_neg;
			sat_q <= n_sat;
			hex_q <= n_hex;
			left_q <= n_left;
			seen_q <= n_seen;
			count_q <= n_count;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (advance) begin
			result_valid_q <= valid_s1 && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1 && emit) begin
			result_q <= fin;
		end
	end

endmodule

`default_nettype wire

### tb/sv/integer_field_scanner_checker.sv
// Checker that predicts and compares the field results of the integer field scanner.
`timescale 1ns / 100ps

module integer_field_scanner_checker (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 item_valid,
	input  wire                                 item_stall,
	input  isc_pkg::scan_item_t                 item,
	input  wire                                 result_valid,
	input  wire                                 result_stall,
	input  isc_pkg::scan_result_t               result,
	input  wire                                 cfg_write,
	input  wire [isc_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
	input  wire [isc_pkg::CFG_DATA_BITS-1:0]    cfg_data,
	output int                                  mismatch_count,
	output int                                  fields_outstanding
);
	import isc_pkg::*;

	typedef enum logic [2:0] {
		SCAN_BLANK,
		SCAN_SIGN,
		SCAN_ZERO,
		SCAN_PREFIX,
		SCAN_DIGITS,
		SCAN_DONE
	} scan_phase_t;

	logic [1:0]            kind_cfg;
	logic [1:0]            len_cfg;
	logic [WIDTH_BITS-1:0] max_digits_cfg;

	scan_phase_t           phase;
	logic [VALUE_BITS-1:0] acc;
	logic                  negative;
	logic                  clamped;
	logic                  hex_mode;
	logic [WIDTH_BITS-1:0] digits_to_go;
	logic                  got_digit;
	logic [COUNT_BITS-1:0] char_total;

	scan_result_t          expected_fields[$];
	scan_result_t          predicted;
	scan_result_t          oldest;
	int                    errors;

	function automatic void reset_field();
		phase = SCAN_BLANK;
		acc = '0;
		negative = 1'b0;
		clamped = 1'b0;
		hex_mode = 1'b0;
		digits_to_go = '0;
		got_digit = 1'b0;
		char_total = '0;
	endfunction

	function automatic void tally_field_char();
		if (char_total != '1) begin
			char_total++;
		end
	endfunction

	function automatic void emit_field_result(input bit taken,
		output scan_result_t r);
		logic [VALUE_BITS-1:0] v;
		v = '0;
		if (got_digit) begin
			v = negative ? (64'd0 - acc) : acc;
			case (len_cfg)
				LEN_SHORT: v = {48'd0, v[15:0]};
				LEN_INT: v = {32'd0, v[31:0]};
				default: ;
			endcase
		end
		r.value = v;
		r.matched = got_digit;
		r.consumed_count = char_total;
		r.last_char_taken = taken;
		phase = SCAN_DONE;
	endfunction

	// Converts one digit character; a character that is no digit in the base ends the field.
	function automatic bit absorb_digit(input logic [7:0] c, output scan_result_t r);
		int base;
		int d;
		logic [VALUE_BITS-1:0] limit;
		case (kind_cfg)
			KIND_OCTAL: base = 8;
			KIND_UNSIGNED: base = 10;
			KIND_HEX: base = 16;
			default: base = hex_mode ? 16 : 10;
		endcase
		d = -1;
		if (c >= "0" && c <= "9") begin
			d = c - "0";
		end else if (c >= "a" && c <= "f") begin
			d = c - "a" + 10;
		end else if (c >= "A" && c <= "F") begin
			d = c - "A" + 10;
		end
		if (d < 0 || d >= base) begin
			emit_field_result(1'b0, r);
			return 1'b1;
		end
		tally_field_char();
		limit = (kind_cfg == KIND_SIGNED && !hex_mode) ? SIGNED_MAX : UNSIGNED_MAX;
		if (!clamped) begin
			if (acc > (limit - 64'(d)) / 64'(base)) begin
				acc = limit;
				clamped = 1'b1;
			end else begin
				acc = acc * 64'(base) + 64'(d);
			end
		end
		got_digit = 1'b1;
		phase = SCAN_DIGITS;
		if (digits_to_go == 1) begin
			emit_field_result(1'b1, r);
			return 1'b1;
		end
		if (digits_to_go > 1) begin
			digits_to_go--;
		end
		return 1'b0;
	endfunction

	function automatic bit step_field(input scan_item_t beat, output scan_result_t r);
		r = '0;
		if (beat.field_start) begin
			reset_field();
		end
		case (phase)
			SCAN_BLANK: begin
				if (beat.ch == " " || beat.ch == "\t" || beat.ch == "\n") begin
					tally_field_char();
					return 1'b0;
				end
				digits_to_go = max_digits_cfg;
				if (kind_cfg == KIND_SIGNED && (beat.ch == "+" || beat.ch == "-")) begin
					negative = (beat.ch == "-");
					tally_field_char();
					phase = SCAN_SIGN;
					return 1'b0;
				end
				if ((kind_cfg == KIND_SIGNED || kind_cfg == KIND_HEX) && beat.ch == "0") begin
					tally_field_char();
					phase = SCAN_ZERO;
					return 1'b0;
				end
				return absorb_digit(beat.ch, r);
			end
			SCAN_ZERO: begin
				if (beat.ch == "x") begin
					tally_field_char();
					hex_mode = 1'b1;
					phase = SCAN_PREFIX;
					return 1'b0;
				end
				// The held zero turns out to be a digit of its own.
				got_digit = 1'b1;
				phase = SCAN_DIGITS;
				if (digits_to_go == 1) begin
					emit_field_result(1'b0, r);
					return 1'b1;
				end
				if (digits_to_go > 1) begin
					digits_to_go--;
				end
				return absorb_digit(beat.ch, r);
			end
			SCAN_SIGN, SCAN_PREFIX, SCAN_DIGITS: return absorb_digit(beat.ch, r);
			default: return 1'b0;
		endcase
	endfunction

	task automatic flag_field(input string name, input logic [63:0] want,
		input logic [63:0] seen);
		if (want !== seen) begin
			errors++;
			$display("%0t ns: %s expected %0h actual %0h", $time, name, want, seen);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_cfg = KIND_SIGNED;
			len_cfg = LEN_INT;
			max_digits_cfg = '0;
			reset_field();
			expected_fields.delete();
			errors = 0;
		end else begin
			if (cfg_write) begin
				case (cfg_index)
					CFG_CONV_KIND: kind_cfg = cfg_data[1:0];
					CFG_LENGTH_MODE: len_cfg = cfg_data[1:0];
					CFG_FIELD_WIDTH: max_digits_cfg = cfg_data[WIDTH_BITS-1:0];
					default: ;
				endcase
			end
			if (result_valid && !result_stall) begin
				if (expected_fields.size() == 0) begin
					errors++;
					$display({"%0t ns: result beat expected none, ",
						"actual value %0h matched %0b count %0d taken %0b"},
						$time, result.value, result.matched, result.consumed_count,
						result.last_char_taken);
				end else begin
					oldest = expected_fields.pop_front();
					flag_field("value", oldest.value, result.value);
					flag_field("matched", oldest.matched, result.matched);
					flag_field("consumed_count", oldest.consumed_count,
						result.consumed_count);
					flag_field("last_char_taken", oldest.last_char_taken,
						result.last_char_taken);
				end
			end
			if (item_valid && !item_stall) begin
				if (step_field(item, predicted)) begin
					expected_fields.push_back(predicted);
				end
			end
		end
		mismatch_count <= errors;
		fields_outstanding <= expected_fields.size();
	end

endmodule

### tb/sv/tb_top.sv
// Top of the integer field scanner testbench: clock, reset, character stimulus and verdict.
`timescale 1ns / 100ps

module tb_top;
	import isc_pkg::*;

	localparam int LONG_HOLD = 60;
	localparam int SETTLE_CYCLES = 6;
	localparam int ITEMS_PER_SETTING = 100;
	localparam int SETTINGS_PER_PHASE = 4;
	localparam int SETTING_COUNT = 12;
	localparam int LONG_BLANK_RUN = 40;
	localparam logic [1:0] LEN_SPARE = 2'd3;

	logic clk = 1'b0;
	logic arst_n;
	logic item_valid;
	logic item_stall;
	scan_item_t item;
	logic result_valid;
	logic result_stall;
	scan_result_t result;
	logic cfg_write;
	logic [CFG_INDEX_BITS-1:0] cfg_index;
	logic [CFG_DATA_BITS-1:0] cfg_data;

	int mismatch_count;
	int fields_outstanding;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int hold_requests = 0;
	int holds_served = 0;
	int hold_left = 0;
	int items_sent = 0;
	int setting_start;

	logic [1:0] kind_table[SETTING_COUNT] = '{KIND_HEX, KIND_OCTAL, KIND_SIGNED, KIND_UNSIGNED,
		KIND_SIGNED, KIND_HEX, KIND_UNSIGNED, KIND_SIGNED,
		KIND_OCTAL, KIND_SIGNED, KIND_HEX, KIND_UNSIGNED};
	logic [1:0] len_table[SETTING_COUNT] = '{LEN_LONG, LEN_SHORT, LEN_LONG, LEN_INT,
		LEN_SHORT, LEN_SPARE, LEN_LONG, LEN_INT,
		LEN_LONG, LEN_LONG, LEN_SHORT, LEN_LONG};
	logic [7:0] width_table[SETTING_COUNT] = '{8'd255, 8'd1, 8'd0, 8'd2,
		8'd1, 8'd0, 8'd20, 8'd3,
		8'd0, 8'd19, 8'd1, 8'd0};

	integer_field_scanner_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	integer_field_scanner_checker checker_i (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.mismatch_count(mismatch_count),
		.fields_outstanding(fields_outstanding)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	initial begin
		#20_000_000;
		$display("simulation failed");
		$finish;
	end

	// The receiver stalls at random, or for a long stretch each time one is requested.
	initial begin
		result_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_requests != holds_served) begin
				holds_served = hold_requests;
				hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				result_stall <= 1'b1;
			end else begin
				result_stall <= ($urandom_range(99) < recv_idle_pct);
			end
		end
	end

	function automatic scan_item_t make_char_beat(input logic [7:0] c, input logic start);
		scan_item_t beat;
		beat.ch = c;
		beat.field_start = start;
		return beat;
	endfunction

	task automatic offer_char(input scan_item_t beat);
		while ($urandom_range(99) < send_idle_pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		item <= beat;
		@(posedge clk);
		while (item_stall) begin
			@(posedge clk);
		end
		items_sent++;
	endtask

	task automatic offer_text(input string s, input bit start);
		for (int i = 0; i < s.len(); i++) begin
			offer_char(make_char_beat(s[i], start && i == 0));
		end
	endtask

	task automatic wait_for_drain();
		item_valid <= 1'b0;
		@(posedge clk);
		while (fields_outstanding != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Blanks, an optional sign and prefix, digits of the base, then an optional terminator and some tail.
	task automatic offer_field(input logic [1:0] kind);
		scan_item_t text[$];
		int pick;
		int n;
		int base;
		bit prefixed;
		logic [7:0] c;
		n = $urandom_range(3);
		repeat (n) begin
			pick = $urandom_range(2);
			text.push_back(make_char_beat(pick == 0 ? " " : (pick == 1 ? "\t" : "\n"), 1'b0));
		end
		if ($urandom_range(9) < (kind == KIND_SIGNED ? 5 : 1)) begin
			text.push_back(make_char_beat($urandom_range(1) ? "+" : "-", 1'b0));
		end
		prefixed = ($urandom_range(3) == 0);
		if (prefixed) begin
			text.push_back(make_char_beat("0", 1'b0));
			text.push_back(make_char_beat("x", 1'b0));
		end
		base = (kind == KIND_OCTAL) ? 8 : (kind == KIND_UNSIGNED) ? 10 :
			(kind == KIND_HEX || prefixed) ? 16 : 10;
		pick = $urandom_range(9);
		n = (pick < 7) ? $urandom_range(6, 1) : ((pick < 9) ? $urandom_range(24, 15) : 0);
		repeat (n) begin
			pick = $urandom_range(base - 1);
			if (pick < 10) begin
				c = 8'("0" + pick);
			end else begin
				c = 8'(($urandom_range(1) ? "a" : "A") + pick - 10);
			end
			text.push_back(make_char_beat(c, 1'b0));
		end
		case ($urandom_range(5))
			0: text.push_back(make_char_beat(8'h00, 1'b0));
			1: text.push_back(make_char_beat(" ", 1'b0));
			2: text.push_back(make_char_beat(",", 1'b0));
			3: text.push_back(make_char_beat(8'($urandom), 1'b0));
			4: text.push_back(make_char_beat("x", 1'b0));
			default: ;
		endcase
		repeat ($urandom_range(2)) text.push_back(make_char_beat(8'($urandom), 1'b0));
		if (text.size() == 0) begin
			text.push_back(make_char_beat("7", 1'b0));
		end
		text[0].field_start = ($urandom_range(19) != 0);
		foreach (text[i]) begin
			offer_char(text[i]);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		item_valid = 1'b0;
		item = '0;
		cfg_write = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 27;
		recv_idle_pct <= 87;
		// After reset a field is already open, so the first text needs no start.
		offer_text(" -12,", 1'b0);
		offer_text("+", 1'b1);
		offer_char(make_char_beat(8'h00, 1'b0));
		offer_text("0x1F ", 1'b1);
		offer_text("0xg", 1'b1);
		offer_text("07", 1'b1);
		offer_char(make_char_beat(8'h00, 1'b0));
		offer_text("0", 1'b1);
		offer_char(make_char_beat(8'h00, 1'b0));
		offer_text("\t\n9a", 1'b1);
		offer_char(make_char_beat(8'hFF, 1'b1));
		wait_for_drain();

		for (int s = 0; s < SETTING_COUNT; s++) begin
			case (s / SETTINGS_PER_PHASE)
				0: begin
					send_idle_pct = 27;
					recv_idle_pct <= 87;
				end
				1: begin
					send_idle_pct = 87;
					recv_idle_pct <= 27;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct <= 0;
				end
			endcase
			cfg_write <= 1'b1;
			cfg_index <= CFG_CONV_KIND;
			cfg_data <= {6'd0, kind_table[s]};
			@(posedge clk);
			cfg_index <= CFG_LENGTH_MODE;
			cfg_data <= {6'd0, len_table[s]};
			@(posedge clk);
			cfg_index <= CFG_FIELD_WIDTH;
			cfg_data <= width_table[s];
			@(posedge clk);
			cfg_write <= 1'b0;

			// With one digit per field every start beat ends a field, so a long receiver
			// hold fills the block and backs up its input.
			if (width_table[s] == 8'd1) begin
				hold_requests <= hold_requests + 1;
				repeat (24) offer_char(make_char_beat(8'("1" + $urandom_range(6)), 1'b1));
			end

			setting_start = items_sent;
			while (items_sent - setting_start < ITEMS_PER_SETTING) begin
				if ($urandom_range(99) < 15) begin
					repeat ($urandom_range(4, 1)) begin
						offer_char(make_char_beat(8'($urandom), $urandom_range(3) == 0));
					end
				end else begin
					offer_field(kind_table[s]);
				end
			end

			if (s == SETTING_COUNT - 1) begin
				offer_char(make_char_beat(" ", 1'b1));
				repeat (LONG_BLANK_RUN) offer_char(make_char_beat(" ", 1'b0));
				offer_text("5", 1'b0);
				offer_char(make_char_beat(8'h00, 1'b0));
			end
			wait_for_drain();
		end

		if (mismatch_count == 0 && fields_outstanding == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule

### sim.f
rtl/isc_pkg.sv
rtl/integer_field_scanner_unit.sv
tb/sv/integer_field_scanner_checker.sv
tb/sv/tb_top.sv
